[sv/lebd_pkg.sv]
`default_nettype none

package lebd_pkg;

    localparam int unsigned GroupWidth = 7;
    localparam int unsigned ValueWidth = 64;
    localparam int unsigned IdxWidth   = 4;
    localparam int unsigned BitsWidth  = 7;
    localparam int unsigned CountWidth = 4;

    localparam logic [BitsWidth-1:0] FullLimit = 7'd64;
    localparam logic [IdxWidth-1:0]  LastExtIdx = 4'd8;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_TOO_MANY     = 2'd1,
        ST_BAD_SIGNED   = 2'd2,
        ST_BAD_UNSIGNED = 2'd3
    } lebd_status_t;

    // one classified word handed from the front to the back
    typedef struct packed {
        logic [GroupWidth-1:0] group;
        logic [IdxWidth-1:0]   idx;
        logic                  last;
        logic                  sign_ext;
        lebd_status_t          status;
        logic [CountWidth-1:0] count;
    } lebd_op_t;

endpackage

`default_nettype wire

[sv/lebd_if.sv]
`default_nettype none

interface lebd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_signed;
    logic [6:0] max_bits;

    modport source (output valid, output data_byte, output is_signed, output max_bits,
                     input ready);
    modport sink (input valid, input data_byte, input is_signed, input max_bits,
                   output ready);
endinterface

interface lebd_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic [1:0]  status;
    logic [3:0]  byte_count;

    modport source (output valid, output value, output status, output byte_count,
                     input ready);
    modport sink (input valid, input value, input status, input byte_count,
                   output ready);
endinterface

`default_nettype wire

[sv/lebd_front.sv]
`default_nettype none

module lebd_front (
    input  wire logic       clk,
    input  wire logic       rst_n,
    lebd_in_if.sink         coded,
    output lebd_pkg::lebd_op_t push_op,
    output logic            push,
    input  wire logic       full
);

    logic [lebd_pkg::IdxWidth-1:0]  idx_reg;
    logic [lebd_pkg::IdxWidth-1:0]  idx_next;
    logic [lebd_pkg::BitsWidth-1:0] lim;
    logic [lebd_pkg::BitsWidth-1:0] taken;
    logic [lebd_pkg::BitsWidth-1:0] taken_after;
    logic [lebd_pkg::BitsWidth-1:0] pos_wide;
    logic [2:0]                     pos;
    logic [6:0]                     pad;
    logic [6:0]                     grp;
    logic                           sgn_bit;
    logic                           accept;

    assign coded.ready = !full;
    assign accept      = coded.valid && !full;
    assign push        = accept;

    assign lim = (coded.max_bits > lebd_pkg::FullLimit) ? lebd_pkg::FullLimit
                                                        : coded.max_bits;
    assign taken       = lebd_pkg::BitsWidth'(idx_reg) * 7'd7;
    assign taken_after = taken + 7'd7;
    assign pos_wide    = lim - taken - 7'd1;
    assign pos         = pos_wide[2:0];
    assign grp         = coded.data_byte[6:0];
    assign pad         = ~((7'd2 << pos) - 7'd1);
    assign sgn_bit     = grp[pos];

    always_comb
    begin
        push_op.group    = grp;
        push_op.idx      = idx_reg;
        push_op.count    = idx_reg + 4'd1;
        push_op.last     = 1'b0;
        push_op.status   = lebd_pkg::ST_OK;
        push_op.sign_ext = coded.is_signed && coded.data_byte[6]
                           && (idx_reg <= lebd_pkg::LastExtIdx);
        priority if (taken >= lim)
        begin
            push_op.last   = 1'b1;
            push_op.status = lebd_pkg::ST_TOO_MANY;
        end
        else if ((taken_after > lim) && coded.is_signed && sgn_bit && ((grp & pad) != pad))
        begin
            push_op.last   = 1'b1;
            push_op.status = lebd_pkg::ST_BAD_SIGNED;
        end
        else if ((taken_after > lim) && !(coded.is_signed && sgn_bit)
                 && ((grp & pad) != 7'd0))
        begin
            push_op.last   = 1'b1;
            push_op.status = lebd_pkg::ST_BAD_UNSIGNED;
        end
        else if (!coded.data_byte[7])
        begin
            push_op.last = 1'b1;
        end
        else
        begin
            push_op.last = 1'b0;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (accept)
        begin
            idx_next = push_op.last ? '0 : idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

`default_nettype wire

[sv/lebd_fifo.sv]
`default_nettype none

module lebd_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire lebd_pkg::lebd_op_t push_op,
    output logic                    full,
    input  wire logic               pop,
    output lebd_pkg::lebd_op_t      pop_op,
    output logic                    empty
);

    lebd_pkg::lebd_op_t mem_reg [2];
    logic               wr_ptr_reg;
    logic               wr_ptr_next;
    logic               rd_ptr_reg;
    logic               rd_ptr_next;
    logic [1:0]         cnt_reg;
    logic [1:0]         cnt_next;

    assign full   = (cnt_reg == 2'd2);
    assign empty  = (cnt_reg == 2'd0);
    assign pop_op = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

[sv/lebd_back.sv]
`default_nettype none

module lebd_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lebd_pkg::lebd_op_t pop_op,
    input  wire logic               empty,
    output logic                    pop,
    lebd_out_if.source              result
);

    logic [lebd_pkg::ValueWidth-1:0] acc_reg;
    logic [lebd_pkg::ValueWidth-1:0] acc_next;
    logic                            valid_reg;
    logic                            valid_next;
    logic [lebd_pkg::ValueWidth-1:0] value_reg;
    logic [lebd_pkg::ValueWidth-1:0] value_next;
    lebd_pkg::lebd_status_t          status_reg;
    lebd_pkg::lebd_status_t          status_next;
    logic [lebd_pkg::CountWidth-1:0] count_reg;
    logic [lebd_pkg::CountWidth-1:0] count_next;
    logic [lebd_pkg::BitsWidth-1:0]  shamt;
    logic [lebd_pkg::BitsWidth-1:0]  ext_shamt;
    logic [lebd_pkg::ValueWidth-1:0] shifted;
    logic [lebd_pkg::ValueWidth-1:0] ext_mask;
    logic [lebd_pkg::ValueWidth-1:0] merged;
    logic                            slot_free;

    assign slot_free = !valid_reg || result.ready;
    assign pop       = !empty && (!pop_op.last || slot_free);

    assign shamt     = lebd_pkg::BitsWidth'(pop_op.idx) * 7'd7;
    assign ext_shamt = shamt + 7'd7;
    assign shifted   = {57'd0, pop_op.group} << shamt;
    assign ext_mask  = pop_op.sign_ext ? ({lebd_pkg::ValueWidth{1'b1}} << ext_shamt) : '0;
    assign merged    = acc_reg | shifted;

    always_comb
    begin
        acc_next    = acc_reg;
        valid_next  = valid_reg && !result.ready;
        value_next  = value_reg;
        status_next = status_reg;
        count_next  = count_reg;
        if (pop)
        begin
            if (pop_op.last)
            begin
                acc_next    = '0;
                valid_next  = 1'b1;
                status_next = pop_op.status;
                count_next  = pop_op.count;
                value_next  = (pop_op.status == lebd_pkg::ST_OK) ? (merged | ext_mask) : '0;
            end
            else
            begin
                acc_next = merged;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg   <= acc_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        status_reg <= status_next;
        count_reg  <= count_next;
    end

    assign result.valid      = valid_reg;
    assign result.value      = value_reg;
    assign result.status     = status_reg;
    assign result.byte_count = count_reg;

endmodule

`default_nettype wire

[sv/leb128_checked_decoder_core.sv]
// LEB128 decoder with limit checks: one encoded byte per word on coded, low
// group first, with is_signed and max_bits (1..64, larger taken as 64) given on
// every byte. A word on result comes out for the final byte of a number or on
// the first byte that breaks the limit (too many bytes, or padding above the
// limit not all zeros / all ones), after which the number restarts. Bytes are
// taken at one per cycle while the queue has room; the closing byte is queued,
// then merged by the back into the result register. The front classifies each
// byte against the group count, a two-word queue decouples it from the back,
// which merges the 7-bit group into the 64-bit accumulator with one shift.
`default_nettype none

module leb128_checked_decoder_core (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lebd_in_if.sink    coded,
    lebd_out_if.source result
);

    lebd_pkg::lebd_op_t push_op;
    lebd_pkg::lebd_op_t pop_op;
    logic               push;
    logic               pop;
    logic               full;
    logic               empty;

    lebd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .coded   (coded),
        .push_op (push_op),
        .push    (push),
        .full    (full)
    );

    lebd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .full    (full),
        .pop     (pop),
        .pop_op  (pop_op),
        .empty   (empty)
    );

    lebd_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .pop_op (pop_op),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

endmodule

`default_nettype wire

[sv/lebd_checker.sv]
`default_nettype none

module lebd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [63:0] out_value,
    input wire logic [1:0]  out_status,
    input wire logic [3:0]  out_byte_count
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value)
                                    && $stable(out_status) && $stable(out_byte_count))
    else $error("result changed while stalled");

    // errors carry a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status != lebd_pkg::ST_OK) |-> out_value == 64'd0)
    else $error("error result with nonzero value");

    // a number spans one to eleven bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_byte_count != 4'd0) && (out_byte_count <= 4'd11))
    else $error("byte count out of range");

    // a good number never runs past ten bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status == lebd_pkg::ST_OK) |-> out_byte_count <= 4'd10)
    else $error("good number longer than ten bytes");

endmodule

bind leb128_checked_decoder_core lebd_checker u_lebd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .out_value      (result.value),
    .out_status     (result.status),
    .out_byte_count (result.byte_count)
);

`default_nettype wire
